// ===== sv/pfa_pkg.sv =====
`default_nettype none

package pfa_pkg;

    localparam int NUM_FRAMES       = 32768;
    localparam int FIRST_FREE_FRAME = 256;
    localparam int COUNT_WIDTH      = 8;

    localparam int ADDR_W  = $clog2(NUM_FRAMES);
    localparam int FILL_W  = ADDR_W + 1;
    localparam int FRAME_W = 15;
    localparam int OUT_CNT_W = 8;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_INCR  = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_FREE   = 3'd1,
        ST_RANGE     = 3'd2,
        ST_UNREF     = 3'd3,
        ST_SATURATED = 3'd4
    } t_status;

    typedef struct packed {
        t_action              action;
        logic [FRAME_W-1:0]   frame;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [FRAME_W-1:0]   given_frame;
        logic [OUT_CNT_W-1:0] count_now;
        logic                 returned_to_pool;
    } t_rsp;

    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_EXEC  = 2'd2
    } t_state;

    typedef struct packed {
        logic clear_step;
        logic accept;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
    } t_sts;

endpackage

`default_nettype wire

// ===== sv/pfa_ctrl.sv =====
`default_nettype none

module pfa_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    output pfa_pkg::t_cmd      o_cmd,
    input  wire pfa_pkg::t_sts i_sts
);

    pfa_pkg::t_state r_state;
    pfa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfa_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_cmd.clear_step = 1'b0;
        o_cmd.accept     = 1'b0;
        o_cmd.exec       = 1'b0;
        busy             = 1'b1;
        unique case (r_state)
            pfa_pkg::S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = pfa_pkg::S_IDLE;
                end
            end
            pfa_pkg::S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.accept = 1'b1;
                    n_state      = pfa_pkg::S_EXEC;
                end
            end
            pfa_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = pfa_pkg::S_IDLE;
            end
            default: begin
                n_state = pfa_pkg::S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/pfa_datapath.sv =====
`default_nettype none

module pfa_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire pfa_pkg::t_cmd i_cmd,
    output pfa_pkg::t_sts      o_sts,
    input  wire pfa_pkg::t_req i_req,
    output logic               o_valid,
    output pfa_pkg::t_rsp      o_rsp
);

    localparam int AW = pfa_pkg::ADDR_W;
    localparam int FW = pfa_pkg::FILL_W;
    localparam int CW = pfa_pkg::COUNT_WIDTH;

    logic [CW-1:0] cnt_mem [pfa_pkg::NUM_FRAMES];
    logic [AW-1:0] stk_mem [pfa_pkg::NUM_FRAMES];

    logic [AW-1:0] r_clr;
    logic [FW-1:0] r_fill;
    logic [FW-1:0] n_fill;
    logic [AW-1:0] r_fresh;
    logic [AW-1:0] n_fresh;
    logic          r_spent;
    logic          n_spent;
    logic          r_valid;

    pfa_pkg::t_req r_req;
    pfa_pkg::t_rsp r_rsp;
    pfa_pkg::t_rsp n_rsp;
    logic [CW-1:0] r_cnt_q;
    logic [AW-1:0] r_stk_q;

    logic          cnt_we;
    logic [AW-1:0] cnt_wa;
    logic [CW-1:0] cnt_wd;
    logic          stk_we;
    logic [AW-1:0] stk_wa;

    logic          in_range;
    logic [AW-1:0] idx;
    logic [AW-1:0] got;
    logic [CW-1:0] cnt_dec;

    assign o_sts.clear_last = (r_clr == AW'(pfa_pkg::NUM_FRAMES - 1));

    assign in_range = (32'(r_req.frame) >= 32'(pfa_pkg::FIRST_FREE_FRAME))
                   && (32'(r_req.frame) < 32'(pfa_pkg::NUM_FRAMES));
    assign idx      = AW'(r_req.frame);
    assign cnt_dec  = r_cnt_q - CW'(1);

    always_comb begin
        n_fill  = r_fill;
        n_fresh = r_fresh;
        n_spent = r_spent;
        n_rsp   = '0;
        n_rsp.status = pfa_pkg::ST_OK;
        cnt_we  = 1'b0;
        cnt_wa  = idx;
        cnt_wd  = '0;
        stk_we  = 1'b0;
        stk_wa  = AW'(r_fill);
        got     = r_stk_q;
        if (i_cmd.clear_step) begin
            cnt_we = 1'b1;
            cnt_wa = r_clr;
        end else if (i_cmd.exec) begin
            if (r_req.action == pfa_pkg::ACT_ALLOC) begin
                if (r_fill != '0) begin
                    got    = r_stk_q;
                    n_fill = r_fill - FW'(1);
                end else if (!r_spent && (32'(r_fresh) >=
                             32'(pfa_pkg::FIRST_FREE_FRAME))) begin
                    got = r_fresh;
                    if (r_fresh == '0) begin
                        n_spent = 1'b1;
                    end else begin
                        n_fresh = r_fresh - AW'(1);
                    end
                end else begin
                    n_rsp.status = pfa_pkg::ST_NO_FREE;
                end
                if (n_rsp.status == pfa_pkg::ST_OK) begin
                    cnt_we            = 1'b1;
                    cnt_wa            = got;
                    cnt_wd            = CW'(1);
                    n_rsp.given_frame = pfa_pkg::FRAME_W'(got);
                    n_rsp.count_now   = pfa_pkg::OUT_CNT_W'(1);
                end
            end else if (!in_range) begin
                n_rsp.status = pfa_pkg::ST_RANGE;
            end else begin
                unique case (r_req.action)
                    pfa_pkg::ACT_FREE: begin
                        if (r_cnt_q == '0) begin
                            n_rsp.status = pfa_pkg::ST_UNREF;
                        end else begin
                            cnt_we          = 1'b1;
                            cnt_wd          = cnt_dec;
                            n_rsp.count_now = pfa_pkg::OUT_CNT_W'(cnt_dec);
                            if ((cnt_dec == '0) &&
                                (32'(r_fill) < 32'(pfa_pkg::NUM_FRAMES))) begin
                                stk_we                 = 1'b1;
                                n_fill                 = r_fill + FW'(1);
                                n_rsp.returned_to_pool = 1'b1;
                            end
                        end
                    end
                    pfa_pkg::ACT_INCR: begin
                        if (r_cnt_q == '0) begin
                            n_rsp.status = pfa_pkg::ST_UNREF;
                        end else if (r_cnt_q == pfa_pkg::COUNT_MAX) begin
                            n_rsp.status    = pfa_pkg::ST_SATURATED;
                            n_rsp.count_now = pfa_pkg::OUT_CNT_W'(r_cnt_q);
                        end else begin
                            cnt_we          = 1'b1;
                            cnt_wd          = r_cnt_q + CW'(1);
                            n_rsp.count_now = pfa_pkg::OUT_CNT_W'(r_cnt_q + CW'(1));
                        end
                    end
                    pfa_pkg::ACT_READ: begin
                        n_rsp.count_now = pfa_pkg::OUT_CNT_W'(r_cnt_q);
                    end
                    default: begin
                        n_rsp.status = pfa_pkg::ST_OK;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        if (i_cmd.accept) begin
            r_cnt_q <= cnt_mem[AW'(i_req.frame)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stk_mem[stk_wa] <= idx;
        end
        if (i_cmd.accept) begin
            r_stk_q <= stk_mem[AW'(r_fill - FW'(1))];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_req;
        end
        if (i_cmd.exec) begin
            r_rsp <= n_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_fill  <= '0;
            r_fresh <= AW'(pfa_pkg::NUM_FRAMES - 1);
            r_spent <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_step) begin
                r_clr <= r_clr + AW'(1);
            end
            r_fill  <= n_fill;
            r_fresh <= n_fresh;
            r_spent <= n_spent;
            r_valid <= i_cmd.exec;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

`default_nettype wire

// ===== sv/page_frame_allocator_refcount_unit.sv =====
// A request is taken in the idle state and run in the exec state; its result is then registered.
// No request is taken in the exec state (busy high), due to the count memory read-modify-write.
// The receiver cannot stall; every result must be taken in the cycle it is shown.
// After reset the count memory is cleared one entry a cycle, all 32768 entries, with busy high.
// The freed-frame stack is not cleared; only entries written earlier are ever used.
`default_nettype none

module page_frame_allocator_refcount_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire pfa_pkg::t_req i_req,
    output logic               o_valid,
    output pfa_pkg::t_rsp      o_rsp
);

    pfa_pkg::t_cmd cmd;
    pfa_pkg::t_sts sts;

    pfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    pfa_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire
